### design/binary_xml_number_token_encoder_assert.svh
// Assertion macros shared by the number token encoder.
`ifndef BINARY_XML_NUMBER_TOKEN_ENCODER_ASSERT_SVH
`define BINARY_XML_NUMBER_TOKEN_ENCODER_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define BXN_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("number token encoder: implication failed");

// Next-cycle implication, checked during reset as well.
`define BXN_ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("number token encoder: next-cycle check failed");

`endif

### design/bxnum_pkg.sv
// ---------------------------------------------------------------------------
// bxnum_pkg
// Types and constants of the binary-XML number token encoder.
// ---------------------------------------------------------------------------
package bxnum_pkg;

   // Input value kinds.
   localparam logic [2:0] KIND_DOUBLE = 3'd0;
   localparam logic [2:0] KIND_FLOAT  = 3'd1;
   localparam logic [2:0] KIND_INT64  = 3'd2;
   localparam logic [2:0] KIND_INT32  = 3'd3;
   localparam logic [2:0] KIND_BOOL   = 3'd4;

   // Text token codes.
   localparam logic [7:0] TOK_ZERO   = 8'h80;
   localparam logic [7:0] TOK_ONE    = 8'h82;
   localparam logic [7:0] TOK_FALSE  = 8'h84;
   localparam logic [7:0] TOK_TRUE   = 8'h86;
   localparam logic [7:0] TOK_INT8   = 8'h88;
   localparam logic [7:0] TOK_INT16  = 8'h8A;
   localparam logic [7:0] TOK_INT32  = 8'h8C;
   localparam logic [7:0] TOK_INT64  = 8'h8E;
   localparam logic [7:0] TOK_FLOAT  = 8'h90;
   localparam logic [7:0] TOK_DOUBLE = 8'h92;

   // Value class as it travels down the narrowing pipeline.
   typedef enum logic [2:0] {
      CLS_NONE,
      CLS_DBL,
      CLS_FLT,
      CLS_I64,
      CLS_TRUE,
      CLS_FALSE
   } cls_type;

   // Finished token handed to the serialiser.
   typedef struct packed {
      logic        valid;
      logic        none;
      logic [7:0]  code;
      logic [63:0] payload;
      logic [3:0]  nbytes;
   } token_type;

endpackage

### design/binary_xml_number_token_encoder.sv
// ---------------------------------------------------------------------------
// binary_xml_number_token_encoder
// Narrows a typed number to its shortest binary-XML text token and sends
// the token as a byte stream.
// ---------------------------------------------------------------------------
// Channel   Direction  Ports                                   Transfer
// request   in         start, busy, req_kind, req_value_bits   start && !busy
// response  out        rsp_strobe, rsp_out_byte, rsp_last_byte rsp_strobe
//
// Three register stages (double to float, float to integer, token choice)
// feed a serialiser. A request enters in any cycle the first stage can move.
// Each item gives 1 to 9 output bytes, the code byte and then the payload;
// the serialiser port sets the sustained rate. Reset clears all valid bits;
// the receiver never stalls the output.
// ---------------------------------------------------------------------------
`include "binary_xml_number_token_encoder_assert.svh"

module binary_xml_number_token_encoder
   import bxnum_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_kind,
   input  logic [63:0] req_value_bits,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_byte
);

   logic        a_valid_ff, b_valid_ff, c_valid_ff;
   logic [2:0]  a_kind_ff;
   logic [63:0] a_bits_ff;
   cls_type     b_cls_ff, b_cls_in, c_cls_ff, c_cls_in;
   logic [63:0] b_pay_ff, b_pay_in, c_pay_ff, c_pay_in;
   token_type   tok;
   logic        ser_ready, c_go, b_go, a_go;

   // Stage hand-off: each stage moves when the next one frees up.
   assign c_go = c_valid_ff && ser_ready;
   assign b_go = b_valid_ff && (!c_valid_ff || ser_ready);
   assign a_go = a_valid_ff && (!b_valid_ff || !c_valid_ff || ser_ready);
   assign busy = a_valid_ff && !a_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (start && !busy) begin
            a_valid_ff <= 1'b1;
         end else if (a_go) begin
            a_valid_ff <= 1'b0;
         end
         if (a_go) begin
            b_valid_ff <= 1'b1;
         end else if (b_go) begin
            b_valid_ff <= 1'b0;
         end
         if (b_go) begin
            c_valid_ff <= 1'b1;
         end else if (c_go) begin
            c_valid_ff <= 1'b0;
         end
      end
      if (start && !busy) begin
         a_kind_ff <= req_kind;
         a_bits_ff <= req_value_bits;
      end
      if (a_go) begin
         b_cls_ff <= b_cls_in;
         b_pay_ff <= b_pay_in;
      end
      if (b_go) begin
         c_cls_ff <= c_cls_in;
         c_pay_ff <= c_pay_in;
      end
   end

   // Stage one: sort the kind and narrow an exact double to a float.
   logic               d_sign;
   logic [10:0]        d_exp;
   logic [51:0]        d_man;
   logic signed [12:0] d_unb;
   logic [5:0]         d_sh;
   logic [52:0]        d_sig, d_mask, d_den;
   always_comb begin
      d_sign   = a_bits_ff[63];
      d_exp    = a_bits_ff[62:52];
      d_man    = a_bits_ff[51:0];
      d_unb    = $signed({2'b00, d_exp}) - 13'sd1023;
      d_sh     = 6'(-13'sd97 - d_unb);
      d_sig    = {1'b1, d_man};
      d_mask   = (53'd1 << d_sh) - 53'd1;
      d_den    = d_sig >> d_sh;
      b_cls_in = CLS_NONE;
      b_pay_in = a_bits_ff;
      case (a_kind_ff)
         KIND_DOUBLE: begin
            b_cls_in = CLS_DBL;
            if (d_exp == 11'd0 && d_man == 52'd0) begin
               b_cls_in = CLS_FLT;
               b_pay_in = {32'd0, d_sign, 31'd0};
            end else if (d_exp == 11'd0 || d_exp == 11'h7FF) begin
               b_cls_in = CLS_DBL;
            end else if (d_unb >= -13'sd126 && d_unb <= 13'sd127) begin
               if (d_man[28:0] == 29'd0) begin
                  b_cls_in = CLS_FLT;
                  b_pay_in = {32'd0, d_sign, 8'(d_unb + 13'sd127), d_man[51:29]};
               end
            end else if (d_unb >= -13'sd149 && d_unb <= -13'sd127) begin
               if ((d_sig & d_mask) == 53'd0) begin
                  b_cls_in = CLS_FLT;
                  b_pay_in = {32'd0, d_sign, 8'd0, d_den[22:0]};
               end
            end
         end
         KIND_FLOAT: begin
            b_cls_in = CLS_FLT;
            b_pay_in = {32'd0, a_bits_ff[31:0]};
         end
         KIND_INT64: begin
            b_cls_in = CLS_I64;
         end
         KIND_INT32: begin
            b_cls_in = CLS_I64;
            b_pay_in = {{32{a_bits_ff[31]}}, a_bits_ff[31:0]};
         end
         KIND_BOOL: begin
            b_cls_in = (a_bits_ff != 64'd0) ? CLS_TRUE : CLS_FALSE;
         end
         default: begin
            b_cls_in = CLS_NONE;
         end
      endcase
   end

   // Stage two: turn a float that is an exact integer into an int64.
   logic              f_sign;
   logic [7:0]        f_exp;
   logic [22:0]       f_man;
   logic signed [9:0] f_unb;
   logic [63:0]       f_sig, f_mag;
   logic [22:0]       f_mask;
   always_comb begin
      f_sign   = b_pay_ff[31];
      f_exp    = b_pay_ff[30:23];
      f_man    = b_pay_ff[22:0];
      f_unb    = $signed({2'b00, f_exp}) - 10'sd127;
      f_sig    = {40'd0, 1'b1, f_man};
      f_mask   = (f_unb < 10'sd23) ? 23'((24'd1 << 5'(10'sd23 - f_unb)) - 24'd1) : 23'd0;
      f_mag    = (f_unb >= 10'sd23) ? (f_sig << 6'(f_unb - 10'sd23))
                                    : (f_sig >> 5'(10'sd23 - f_unb));
      c_cls_in = b_cls_ff;
      c_pay_in = b_pay_ff;
      if (b_cls_ff == CLS_FLT) begin
         if (f_exp == 8'd0 && f_man == 23'd0) begin
            c_cls_in = CLS_I64;
            c_pay_in = 64'd0;
         end else if (f_exp == 8'd0 || f_exp == 8'hFF || f_unb < 10'sd0) begin
            c_cls_in = CLS_FLT;
         end else if (f_unb <= 10'sd62) begin
            if ((f_man & f_mask) == 23'd0) begin
               c_cls_in = CLS_I64;
               c_pay_in = f_sign ? (64'd0 - f_mag) : f_mag;
            end
         end else if (f_unb == 10'sd63 && f_sign && f_man == 23'd0) begin
            c_cls_in = CLS_I64;
            c_pay_in = 64'h8000_0000_0000_0000;
         end
      end
   end

   // Stage three: pick the token form and payload length.
   always_comb begin
      tok.valid   = c_valid_ff;
      tok.none    = 1'b0;
      tok.payload = c_pay_ff;
      tok.code    = TOK_DOUBLE;
      tok.nbytes  = 4'd8;
      case (c_cls_ff)
         CLS_DBL: begin
            tok.code   = TOK_DOUBLE;
            tok.nbytes = 4'd8;
         end
         CLS_FLT: begin
            tok.code   = TOK_FLOAT;
            tok.nbytes = 4'd4;
         end
         CLS_I64: begin
            if (c_pay_ff[63:31] != {33{c_pay_ff[63]}}) begin
               tok.code   = TOK_INT64;
               tok.nbytes = 4'd8;
            end else if (c_pay_ff == 64'd0) begin
               tok.code   = TOK_ZERO;
               tok.nbytes = 4'd0;
            end else if (c_pay_ff == 64'd1) begin
               tok.code   = TOK_ONE;
               tok.nbytes = 4'd0;
            end else if (c_pay_ff[63:7] == {57{c_pay_ff[63]}}) begin
               tok.code   = TOK_INT8;
               tok.nbytes = 4'd1;
            end else if (c_pay_ff[63:15] == {49{c_pay_ff[63]}}) begin
               tok.code   = TOK_INT16;
               tok.nbytes = 4'd2;
            end else begin
               tok.code   = TOK_INT32;
               tok.nbytes = 4'd4;
            end
         end
         CLS_TRUE: begin
            tok.code   = TOK_TRUE;
            tok.nbytes = 4'd0;
         end
         CLS_FALSE: begin
            tok.code   = TOK_FALSE;
            tok.nbytes = 4'd0;
         end
         default: begin
            tok.none = 1'b1;
         end
      endcase
   end

   // Byte stream output.
   bxnum_ser u_ser (
      .clock         (clock),
      .reset         (reset),
      .tok           (tok),
      .ready         (ser_ready),
      .rsp_strobe    (rsp_strobe),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );

   // Checks on the pipeline control.
   `BXN_ASSERT_IMP(a_busy_needs_item, clock, reset, busy, a_valid_ff)
   `BXN_ASSERT_IMP(a_last_has_strobe, clock, reset, rsp_last_byte, rsp_strobe)
   `BXN_ASSERT_NEXT(a_reset_quiet, clock, reset, !rsp_strobe && !busy)

endmodule

### design/bxnum_ser.sv
// ---------------------------------------------------------------------------
// bxnum_ser
// Token serialiser: sends the code byte and then the payload bytes, least
// significant first, one byte per cycle.
// ---------------------------------------------------------------------------
module bxnum_ser
   import bxnum_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  token_type  tok,
   output logic       ready,
   output logic       rsp_strobe,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_byte
);

   logic        valid_ff, valid_in;
   logic [71:0] data_ff, data_in;
   logic [3:0]  left_ff, left_in;
   logic        load;

   // A new token may be taken when idle or on the final byte.
   assign ready = !valid_ff || (left_ff == 4'd0);
   assign load  = tok.valid && ready && !tok.none;

   // Next state of the shift register.
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      left_in  = left_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = {tok.payload, tok.code};
         left_in  = tok.nbytes;
      end else if (valid_ff) begin
         if (left_ff == 4'd0) begin
            valid_in = 1'b0;
         end else begin
            data_in = {8'd0, data_ff[71:8]};
            left_in = left_ff - 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
      left_ff <= left_in;
   end

   // Each byte is shown for one cycle only.
   assign rsp_strobe    = valid_ff;
   assign rsp_out_byte  = data_ff[7:0];
   assign rsp_last_byte = valid_ff && (left_ff == 4'd0);

endmodule

### test/tb_number_token_checker.sv
// ---------------------------------------------------------------------------
// Number token checker
// Watches the request and response channels of the number token encoder.
// It predicts the token bytes of each request and compares each response
// byte with the oldest predicted one.
// ---------------------------------------------------------------------------
module tb_number_token_checker
   import bxnum_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [2:0]  req_kind,
   input  logic [63:0] req_value_bits,
   input  logic        rsp_strobe,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_last_byte,
   output int          mismatch_count,
   output int          bytes_awaited
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } token_byte_type;

   localparam logic signed [63:0] INT32_MIN = -64'sd2147483648;
   localparam logic signed [63:0] INT32_MAX = 64'sd2147483647;

   token_byte_type token_bytes[$];

   // Adds one byte to the tail of the expected stream.
   function automatic void append_byte(logic [7:0] value, logic last);
      token_byte_type entry;
      entry.data = value;
      entry.last = last;
      token_bytes.insert(token_bytes.size(), entry);
   endfunction

   // Queues a token: the code byte first, then the payload, low byte first.
   function automatic void queue_token(logic [7:0] code, logic [63:0] payload, int nbytes);
      append_byte(code, nbytes == 0);
      for (int k = 0; k < nbytes; k++)
         append_byte(payload[8*k +: 8], k == nbytes - 1);
   endfunction

   // Integers take the shortest of Zero, One, Int8, Int16, Int32 and Int64.
   function automatic void encode_integer(logic signed [63:0] v);
      if (v < INT32_MIN || v > INT32_MAX)
         queue_token(TOK_INT64, v, 8);
      else if (v == 0)
         queue_token(TOK_ZERO, 64'd0, 0);
      else if (v == 1)
         queue_token(TOK_ONE, 64'd0, 0);
      else if (v >= -128 && v < 128)
         queue_token(TOK_INT8, v, 1);
      else if (v >= -32768 && v < 32768)
         queue_token(TOK_INT16, v, 2);
      else
         queue_token(TOK_INT32, v, 4);
   endfunction

   // A float that is a whole number in [-2^63, 2^63) narrows to an integer.
   function automatic void encode_single(logic [31:0] fb);
      logic        sgn;
      logic [7:0]  ex;
      logic [22:0] man;
      logic [22:0] frac_mask;
      logic [63:0] mag;
      int          x;
      sgn = fb[31];
      ex  = fb[30:23];
      man = fb[22:0];
      x   = int'(ex) - 127;
      if (ex == 8'hFF) begin
         queue_token(TOK_FLOAT, {32'd0, fb}, 4);
      end else if (ex == 8'd0) begin
         // Zero of either sign gives Zero; subnormals are never whole.
         if (man == 23'd0)
            encode_integer(64'sd0);
         else
            queue_token(TOK_FLOAT, {32'd0, fb}, 4);
      end else if (x < 0) begin
         queue_token(TOK_FLOAT, {32'd0, fb}, 4);
      end else if (x >= 63) begin
         // Only -2^63 fits; 2^63 and above stay Float.
         if (sgn && x == 63 && man == 23'd0)
            encode_integer(64'h8000_0000_0000_0000);
         else
            queue_token(TOK_FLOAT, {32'd0, fb}, 4);
      end else begin
         frac_mask = (x < 23) ? ((23'h1 << (23 - x)) - 23'h1) : 23'd0;
         if ((man & frac_mask) != 23'd0) begin
            queue_token(TOK_FLOAT, {32'd0, fb}, 4);
         end else begin
            mag = {40'd0, 1'b1, man};
            mag = (x >= 23) ? (mag << (x - 23)) : (mag >> (23 - x));
            encode_integer(sgn ? -mag : mag);
         end
      end
   endfunction

   // A double that is exactly a float, subnormal floats included, narrows.
   function automatic void encode_wide(logic [63:0] raw);
      logic        sgn;
      logic [10:0] ex;
      logic [51:0] man;
      logic [52:0] sig;
      int          x;
      int          sh;
      sgn = raw[63];
      ex  = raw[62:52];
      man = raw[51:0];
      x   = int'(ex) - 1023;
      sig = {1'b1, man};
      sh  = -x - 97;
      if (ex == 11'h7FF) begin
         queue_token(TOK_DOUBLE, raw, 8);
      end else if (ex == 11'd0) begin
         if (man == 52'd0)
            encode_single({sgn, 31'd0});
         else
            queue_token(TOK_DOUBLE, raw, 8);
      end else if (x > 127 || x < -149) begin
         queue_token(TOK_DOUBLE, raw, 8);
      end else if (x >= -126) begin
         if (man[28:0] != 29'd0)
            queue_token(TOK_DOUBLE, raw, 8);
         else
            encode_single({sgn, 8'(x + 127), man[51:29]});
      end else begin
         // Float subnormal range: the dropped significand bits must be zero.
         if ((sig & ((53'h1 << sh) - 53'h1)) != 53'd0)
            queue_token(TOK_DOUBLE, raw, 8);
         else
            encode_single({sgn, 8'd0, 23'(sig >> sh)});
      end
   endfunction

   // Works out the token bytes of one accepted request.
   function automatic void predict_token(logic [2:0] kind, logic [63:0] bits);
      case (kind)
         KIND_DOUBLE: encode_wide(bits);
         KIND_FLOAT:  encode_single(bits[31:0]);
         KIND_INT64:  encode_integer(bits);
         KIND_INT32:  encode_integer({{32{bits[31]}}, bits[31:0]});
         KIND_BOOL:   queue_token((bits != 64'd0) ? TOK_TRUE : TOK_FALSE, 64'd0, 0);
         default: ;
      endcase
   endfunction

   // Each edge: record an accepted request, then check any response byte.
   always @(posedge clock) begin
      token_byte_type want;
      if (reset) begin
         mismatch_count = 0;
         token_bytes.delete();
      end else begin
         if (start && !busy)
            predict_token(req_kind, req_value_bits);
         if (rsp_strobe) begin
            if (token_bytes.size() == 0) begin
               $error("unexpected response byte %02h", rsp_out_byte);
               mismatch_count++;
            end else begin
               want = token_bytes.pop_front();
               if (rsp_out_byte !== want.data) begin
                  $error("out_byte: expected %02h, actual %02h", want.data, rsp_out_byte);
                  mismatch_count++;
               end
               if (rsp_last_byte !== want.last) begin
                  $error("last_byte: expected %0b, actual %0b", want.last, rsp_last_byte);
                  mismatch_count++;
               end
            end
         end
      end
      bytes_awaited = token_bytes.size();
   end

endmodule

### test/tb_top.sv
// ---------------------------------------------------------------------------
// Number token encoder testbench
// Sends directed corner values and then random typed numbers through the
// encoder, with random gaps between requests, and reports the verdict that
// the checker's mismatch count and its outstanding byte count give.
// ---------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import bxnum_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [2:0]  req_kind = KIND_DOUBLE;
   logic [63:0] req_value_bits = 64'd0;
   logic        busy;
   logic        rsp_strobe;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last_byte;
   int          mismatch_count;
   int          bytes_awaited;
   int          idle_percent = 14;
   int          cycle_count = 0;

   always #6 clock = ~clock;

   binary_xml_number_token_encoder dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_value_bits(req_value_bits),
      .rsp_strobe(rsp_strobe), .rsp_out_byte(rsp_out_byte),
      .rsp_last_byte(rsp_last_byte)
   );

   tb_number_token_checker checker_inst (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_value_bits(req_value_bits),
      .rsp_strobe(rsp_strobe), .rsp_out_byte(rsp_out_byte),
      .rsp_last_byte(rsp_last_byte),
      .mismatch_count(mismatch_count), .bytes_awaited(bytes_awaited)
   );

   // Timeout guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Idle cycles drawn one at a time at the current rate, then one request
   // transfer.
   task automatic send_number(input logic [2:0] kind, input logic [63:0] bits);
      while ($urandom_range(0, 99) < idle_percent) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_kind       <= kind;
      req_value_bits <= bits;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Holds the sender off until every predicted byte has come out.
   task automatic drain_tokens();
      start <= 1'b0;
      @(negedge clock);
      while (bytes_awaited != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // Random value shaped for the kind: raw bits, small integers, numbers
   // that narrow, or powers of two near the range limits.
   function automatic logic [63:0] pick_value(logic [2:0] kind);
      logic [63:0] v;
      logic [51:0] man;
      logic [22:0] fman;
      int          x;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         1: begin
            v = 64'($urandom_range(0, 300));
            if ($urandom_range(0, 1)) v = -v;
         end
         2: begin
            if (kind == KIND_DOUBLE) begin
               x   = $urandom_range(0, 90) - 20;
               man = 52'({$urandom, $urandom});
               man[28:0] = 29'd0;
               if ($urandom_range(0, 1) && x >= 0 && x < 52)
                  man = man & ~((52'h1 << (52 - x)) - 52'h1);
               v = {$urandom_range(0, 1) == 1, 11'(x + 1023), man};
            end else if (kind == KIND_FLOAT) begin
               x    = $urandom_range(0, 70) - 5;
               fman = 23'($urandom);
               if ($urandom_range(0, 1) && x >= 0 && x < 23)
                  fman = fman & ~((23'h1 << (23 - x)) - 23'h1);
               v = {$urandom, $urandom_range(0, 1) == 1, 8'(x + 127), fman};
            end else begin
               v = (64'h1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
               if ($urandom_range(0, 1)) v = -v;
            end
         end
         3: begin
            if (kind == KIND_BOOL) v = 64'd0;
         end
         default: ;
      endcase
      return v;
   endfunction

   initial begin
      logic [2:0] kind;
      int         r;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed corners.
      send_number(KIND_DOUBLE, 64'h0000_0000_0000_0000);
      send_number(KIND_DOUBLE, 64'h8000_0000_0000_0000);    // negative zero
      send_number(KIND_DOUBLE, 64'h3FF0_0000_0000_0000);    // 1.0
      send_number(KIND_DOUBLE, 64'hC060_0000_0000_0000);    // -128.0
      send_number(KIND_DOUBLE, 64'h3FB9_9999_9999_999A);    // 0.1 is not a float
      send_number(KIND_DOUBLE, 64'h3FF8_0000_0000_0000);    // 1.5 narrows to float
      send_number(KIND_DOUBLE, 64'h7FF8_0000_0000_0001);    // NaN
      send_number(KIND_DOUBLE, 64'hFFF0_0000_0000_0000);    // minus infinity
      send_number(KIND_DOUBLE, 64'h43E0_0000_0000_0000);    // 2^63 stays float
      send_number(KIND_DOUBLE, 64'hC3E0_0000_0000_0000);    // -2^63 gives Int64
      send_number(KIND_DOUBLE, 64'h36A0_0000_0000_0000);    // smallest float subnormal
      send_number(KIND_DOUBLE, 64'h0000_0000_0000_0001);    // double subnormal
      send_number(KIND_DOUBLE, 64'h47EF_FFFF_E000_0000);    // largest float
      send_number(KIND_DOUBLE, 64'h7FEF_FFFF_FFFF_FFFF);    // outside float range
      send_number(KIND_FLOAT,  64'hFFFF_FFFF_4300_0000);    // 128.0, upper bits set
      send_number(KIND_FLOAT,  64'h0000_0000_7F80_0000);    // infinity
      send_number(KIND_FLOAT,  64'h0000_0000_8000_0000);    // negative zero
      send_number(KIND_INT64,  64'h7FFF_FFFF_FFFF_FFFF);
      send_number(KIND_INT64,  64'hFFFF_FFFF_8000_0000);    // int32 minimum
      send_number(KIND_INT64,  64'h0000_0000_8000_0000);    // just above int32
      send_number(KIND_INT32,  64'hFFFF_FFFF_0000_007F);
      send_number(KIND_INT32,  64'h0000_0000_0000_0080);    // 128 needs Int16
      send_number(KIND_INT32,  64'h0000_0000_FFFF_8000);
      send_number(KIND_INT32,  64'h0000_0000_0000_8000);
      send_number(KIND_BOOL,   64'h8000_0000_0000_0000);
      send_number(KIND_BOOL,   64'h0000_0000_0000_0000);
      send_number(3'd5, 64'hFFFF_FFFF_FFFF_FFFF);           // undefined kind
      send_number(3'd7, 64'h0);

      // Random phases: light sender gaps, heavy gaps, then back to back.
      for (int phase = 0; phase < 3; phase++) begin
         idle_percent = (phase == 0) ? 14 : (phase == 1) ? 69 : 0;
         for (int n = 0; n < 47; n++) begin
            r    = $urandom_range(0, 20);
            kind = (r < 20) ? 3'(r / 4) : 3'($urandom_range(5, 7));
            send_number(kind, pick_value(kind));
            if (phase == 1 && n == 20) drain_tokens();
         end
      end

      drain_tokens();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && bytes_awaited == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

### binary_xml_number_token_encoder.f
+incdir+design
design/bxnum_pkg.sv
design/bxnum_ser.sv
design/binary_xml_number_token_encoder.sv
test/tb_number_token_checker.sv
test/tb_top.sv
